// ===== rtl/time_window_schedule_queue_assert.svh =====
// ============================================================================
// time_window_schedule_queue_assert.svh
// Assertion macros used by the checker of the window schedule queue.
// ============================================================================
`ifndef TIME_WINDOW_SCHEDULE_QUEUE_ASSERT_SVH
`define TIME_WINDOW_SCHEDULE_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/twsq_pkg.sv =====
// ============================================================================
// twsq_pkg
// Types, codes and constants shared by the window schedule queue modules.
// ============================================================================
`timescale 1ns / 1ps

package twsq_pkg;

    // Default table size and fixed field limits.
    localparam int DEFAULT_CAPACITY = 16;
    localparam int MAX_DUMP         = 16;
    localparam int COUNT_OUT_W      = 5;

    // Configuration port.
    localparam int               APB_AW          = 2;
    localparam logic [APB_AW-1:0] REG_PERIOD_ADDR = 2'd0;
    localparam logic [31:0]      PERIOD_RESET    = 32'd86400;

    // Request codes.
    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_PEEK   = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BAD      = 3'd2;
    localparam logic [2:0] ST_OVERLAP  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    // One request item.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic        repeating;
        logic [4:0]  dump_count;
    } t_req_item;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] start_out;
        logic [31:0] end_out;
        logic        repeat_out;
        logic [4:0]  entry_count;
        logic        last;
    } t_result_item;

    // One stored window.
    typedef struct packed {
        logic [31:0] win_start;
        logic [31:0] win_end;
        logic        win_rep;
    } t_window;

    // Index pointer operations.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_TOP
    } t_idx_op;

    // Table write operations.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT_UP,
        WR_SHIFT_DOWN,
        WR_NEW
    } t_wr_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        t_idx_op    idx_op;
        logic       rd_en;
        t_wr_op     wr_op;
        logic       pos_from_rd;
        logic       pos_from_count;
        logic       prev_latch;
        logic       count_inc;
        logic       count_dec;
        logic       win_from_rd;
        logic       set_status;
        logic [2:0] status;
        logic       load_putback;
        logic       dump_load;
        logic       emit_reg;
        logic       emit_rd;
    } t_dp_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic bad;
        logic count_one;
        logic ge;
        logic ovl_scan;
        logic ovl_cur_end;
        logic at_end;
        logic at_pos;
        logic match;
        logic pb_ok;
        logic dump_zero;
        logic dump_last;
    } t_dp_stat;

endpackage

// ===== rtl/time_window_schedule_queue.sv =====
// ============================================================================
// time_window_schedule_queue
// Sorted table of non-overlapping time windows with push, pop, peek, delete
// and dump requests, and a configurable repeat period.
// ============================================================================
// Usage:
// - Request channel: an item on i_req is taken at a rising edge where start
//   is high and busy is low. busy stays high until the item is finished.
// - Result channel: each result is shown on o_result for one cycle with
//   o_result_valid high; the receiver cannot stall. The final one has last set.
// - Configuration: repeat_period sits at APB byte address 0; pready is
//   always high. Write it only while busy is low.
// - Sequencing: delete scans for its key and shifts the entries above it
//   down; pop shifts the entries down, plus a push when a repeating window
//   is put back. Push scans to its slot, then shifts the entries above it
//   one per cycle. Dump of N windows shows one window per cycle.
// - The next item can be taken in the cycle the final result is shown.
// - Reset empties the table and sets repeat_period to 86400.
// ============================================================================
`timescale 1ns / 1ps

module time_window_schedule_queue
    import twsq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req_item         i_req,
    output logic              o_result_valid,
    output t_result_item      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] r_period;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;

    // Repeat period register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_PERIOD_ADDR)) begin
            r_period <= pwdata;
        end
    end

    assign prdata = (paddr == REG_PERIOD_ADDR) ? r_period : 32'd0;
    assign pready = 1'b1;

    // Sequencer.
    twsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_stat     (dp_stat),
        .o_busy     (busy),
        .o_cmd      (dp_cmd)
    );

    // Table and result datapath.
    twsq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_period       (r_period),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== rtl/twsq_ctrl.sv =====
// ============================================================================
// twsq_ctrl
// Sequencer for the window schedule queue: decodes each item and steps the
// datapath through scans, shifts, writes and result strobes.
// ============================================================================
`timescale 1ns / 1ps

module twsq_ctrl
    import twsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_req_type,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_SCAN,
        S_INS_SHIFT_RD,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_POP_HEAD,
        S_REM_SHIFT,
        S_PB_CHECK,
        S_PEEK_OUT,
        S_DEL_SCAN,
        S_DUMP_OUT,
        S_RESULT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    logic       r_putback, n_putback;

    assign o_busy = (r_state != S_IDLE);

    // State, current operation and put-back flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= REQ_PUSH;
            r_putback <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_putback <= n_putback;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_putback = r_putback;
        o_cmd     = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.wr_op  = WR_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.idx_op   = IDX_ZERO;
                    n_op           = i_req_type;
                    n_putback      = 1'b0;
                    n_state        = S_DECODE;
                end
            end

            // The head entry is read here for every request type.
            S_DECODE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.idx_op = IDX_INC;
                unique case (r_op)
                    REQ_PUSH: begin
                        if (i_stat.bad || i_stat.full) begin
                            if (!r_putback) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = i_stat.bad ? ST_BAD : ST_FULL;
                            end
                            n_state = S_RESULT;
                        end else if (i_stat.empty) begin
                            o_cmd.pos_from_count = 1'b1;
                            n_state              = S_INS_WRITE;
                        end else begin
                            n_state = S_PUSH_SCAN;
                        end
                    end
                    REQ_POP, REQ_PEEK, REQ_DELETE: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_RESULT;
                        end else if (r_op == REQ_POP) begin
                            n_state = S_POP_HEAD;
                        end else if (r_op == REQ_PEEK) begin
                            n_state = S_PEEK_OUT;
                        end else begin
                            n_state = S_DEL_SCAN;
                        end
                    end
                    REQ_DUMP: begin
                        if (i_stat.dump_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = i_stat.empty ? ST_EMPTY : ST_OK;
                            n_state          = S_RESULT;
                        end else begin
                            o_cmd.dump_load = 1'b1;
                            n_state         = S_DUMP_OUT;
                        end
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_BAD;
                        n_state          = S_RESULT;
                    end
                endcase
            end

            // Walk up the table to the first start not below the new start.
            S_PUSH_SCAN: begin
                o_cmd.prev_latch = 1'b1;
                if (i_stat.ge) begin
                    if (i_stat.ovl_scan) begin
                        if (!r_putback) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_OVERLAP;
                        end
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.pos_from_rd = 1'b1;
                        o_cmd.idx_op      = IDX_TOP;
                        n_state           = S_INS_SHIFT_RD;
                    end
                end else if (i_stat.at_end) begin
                    if (i_stat.ovl_cur_end) begin
                        if (!r_putback) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_OVERLAP;
                        end
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.pos_from_count = 1'b1;
                        n_state              = S_INS_WRITE;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end
            end

            // Open a slot: move entries one place up, from the top down.
            S_INS_SHIFT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_INS_SHIFT;
            end

            S_INS_SHIFT: begin
                o_cmd.wr_op = WR_SHIFT_UP;
                if (i_stat.at_pos) begin
                    n_state = S_INS_WRITE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_DEC;
                end
            end

            S_INS_WRITE: begin
                o_cmd.wr_op     = WR_NEW;
                o_cmd.count_inc = 1'b1;
                n_state         = S_RESULT;
            end

            // Keep the head as the reported window, then close the gap.
            S_POP_HEAD: begin
                o_cmd.win_from_rd = 1'b1;
                if (i_stat.count_one) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_PB_CHECK;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_REM_SHIFT;
                end
            end

            // Move entries one place down, from the removed slot up.
            S_REM_SHIFT: begin
                o_cmd.wr_op = WR_SHIFT_DOWN;
                if (i_stat.at_end) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = (r_op == REQ_POP) ? S_PB_CHECK : S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end
            end

            // A repeating head goes back in one period later, as a push, unless a time would pass 2^32-1.
            S_PB_CHECK: begin
                if (i_stat.pb_ok) begin
                    o_cmd.load_putback = 1'b1;
                    o_cmd.idx_op       = IDX_ZERO;
                    n_putback          = 1'b1;
                    n_op               = REQ_PUSH;
                    n_state            = S_DECODE;
                end else begin
                    n_state = S_RESULT;
                end
            end

            S_PEEK_OUT: begin
                o_cmd.win_from_rd = 1'b1;
                n_state           = S_RESULT;
            end

            // Search for the key, then remove the matching entry.
            S_DEL_SCAN: begin
                if (i_stat.match) begin
                    if (i_stat.at_end) begin
                        o_cmd.count_dec = 1'b1;
                        n_state         = S_RESULT;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.idx_op = IDX_INC;
                        n_state      = S_REM_SHIFT;
                    end
                end else if (i_stat.at_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOTFOUND;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end
            end

            // One window per cycle straight from the read port.
            S_DUMP_OUT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_stat.dump_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end
            end

            S_RESULT: begin
                o_cmd.emit_reg = 1'b1;
                n_state        = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/twsq_datapath.sv =====
// ============================================================================
// twsq_datapath
// Window table memory, index pointers, comparators and result register of
// the window schedule queue.
// ============================================================================
`timescale 1ns / 1ps

module twsq_datapath
    import twsq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_req_item    i_req,
    input  logic [31:0]  i_period,
    input  t_dp_cmd      i_cmd,
    output t_dp_stat     o_stat,
    output logic         o_result_valid,
    output t_result_item o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    // Window table, one entry per held window in start order.
    t_window mem [CAPACITY];

    t_req_item    r_req;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_rd_idx;
    t_window      r_rd_data;
    logic [CW-1:0] r_pos;
    logic [31:0]  r_prev_end;
    logic [CW-1:0] r_count;
    logic [2:0]   r_res_status;
    t_window      r_res_win;
    logic [4:0]   r_left;
    logic         r_out_valid;
    t_result_item r_out;

    logic [CW-1:0] wr_addr;
    logic          wr_en;
    t_window       wr_data;
    logic [32:0]   sum_start;
    logic [32:0]   sum_end;
    logic [4:0]    dump_cap;
    logic [XW-1:0] count_x;
    logic [4:0]    dump_n;

    // Table write address and data.
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_pos;
        wr_data = r_rd_data;
        case (i_cmd.wr_op)
            WR_SHIFT_UP:   wr_addr = r_rd_idx + CW'(1);
            WR_SHIFT_DOWN: wr_addr = r_rd_idx - CW'(1);
            WR_NEW: begin
                wr_data.win_start = r_req.start_time;
                wr_data.win_end   = r_req.end_time;
                wr_data.win_rep   = r_req.repeating;
            end
            default:       wr_en = 1'b0;
        endcase
    end

    // Table memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
            r_rd_idx  <= r_idx;
        end
    end

    // Shifted copy of the popped head for the put-back.
    assign sum_start = {1'b0, r_res_win.win_start} + {1'b0, i_period};
    assign sum_end   = {1'b0, r_res_win.win_end} + {1'b0, i_period};

    // Number of windows a dump streams.
    assign dump_cap = (r_req.dump_count > 5'(MAX_DUMP)) ? 5'(MAX_DUMP) : r_req.dump_count;
    assign count_x  = XW'(r_count);
    assign dump_n   = (XW'(dump_cap) < count_x) ? dump_cap : count_x[4:0];

    // Flags for the controller.
    always_comb begin
        o_stat.empty       = (r_count == '0);
        o_stat.full        = (r_count >= CW'(CAPACITY));
        o_stat.bad         = (r_req.end_time <= r_req.start_time);
        o_stat.count_one   = (r_count == CW'(1));
        o_stat.ge          = !(r_rd_data.win_start < r_req.start_time);
        o_stat.ovl_scan    = (r_req.end_time > r_rd_data.win_start)
                           || ((r_rd_idx != '0) && (r_req.start_time < r_prev_end));
        o_stat.ovl_cur_end = (r_req.start_time < r_rd_data.win_end);
        o_stat.at_end      = ((r_rd_idx + CW'(1)) == r_count);
        o_stat.at_pos      = (r_rd_idx == r_pos);
        o_stat.match       = (r_rd_data.win_start == r_req.start_time);
        o_stat.pb_ok       = r_res_win.win_rep && !sum_start[32] && !sum_end[32];
        o_stat.dump_zero   = (dump_n == '0);
        o_stat.dump_last   = (r_left == 5'd1);
    end

    // Held count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Request, pointers and reported window.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end else if (i_cmd.load_putback) begin
            r_req.start_time <= sum_start[31:0];
            r_req.end_time   <= sum_end[31:0];
            r_req.repeating  <= 1'b1;
        end

        case (i_cmd.idx_op)
            IDX_ZERO: r_idx <= '0;
            IDX_INC:  r_idx <= r_idx + CW'(1);
            IDX_DEC:  r_idx <= r_idx - CW'(1);
            IDX_TOP:  r_idx <= r_count - CW'(1);
            default:  r_idx <= r_idx;
        endcase

        if (i_cmd.pos_from_rd) begin
            r_pos <= r_rd_idx;
        end else if (i_cmd.pos_from_count) begin
            r_pos <= r_count;
        end

        if (i_cmd.prev_latch) begin
            r_prev_end <= r_rd_data.win_end;
        end

        if (i_cmd.load_req) begin
            r_res_status <= ST_OK;
            r_res_win    <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
            if (i_cmd.win_from_rd) begin
                r_res_win <= r_rd_data;
            end
        end

        if (i_cmd.dump_load) begin
            r_left <= dump_n;
        end else if (i_cmd.emit_rd) begin
            r_left <= r_left - 5'd1;
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit_reg || i_cmd.emit_rd;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rd) begin
            r_out.status      <= ST_OK;
            r_out.start_out   <= r_rd_data.win_start;
            r_out.end_out     <= r_rd_data.win_end;
            r_out.repeat_out  <= r_rd_data.win_rep;
            r_out.entry_count <= count_x[4:0];
            r_out.last        <= (r_left == 5'd1);
        end else if (i_cmd.emit_reg) begin
            r_out.status      <= r_res_status;
            r_out.start_out   <= r_res_win.win_start;
            r_out.end_out     <= r_res_win.win_end;
            r_out.repeat_out  <= r_res_win.win_rep;
            r_out.entry_count <= count_x[4:0];
            r_out.last        <= 1'b1;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ===== rtl/twsq_checker.sv =====
// ============================================================================
// twsq_checker
// Port-level checks on the result stream of the window schedule queue.
// ============================================================================
`timescale 1ns / 1ps
`include "time_window_schedule_queue_assert.svh"

module twsq_checker
    import twsq_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input logic         o_result_valid,
    input t_result_item o_result
);

    // No result can appear in the cycle right after an item is taken.
    `TWSQ_ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, start && !busy, !o_result_valid, "result right after accept")

    // A dump stream has no gaps before its final item.
    `TWSQ_ASSERT_NEXT(a_stream_gapless, i_clk, i_rst_n, o_result_valid && !o_result.last, o_result_valid, "gap in result stream")

    // The block is free again when the final result is shown.
    `TWSQ_ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_result_valid && o_result.last, !busy, "busy with final result")

    // Results before the final one are successful window reports.
    `TWSQ_ASSERT_SAME(a_stream_ok, i_clk, i_rst_n, o_result_valid && !o_result.last, busy && (o_result.status == ST_OK), "bad status inside stream")

endmodule

bind time_window_schedule_queue twsq_checker u_twsq_checker (.*);

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the time window schedule queue. A directed script
// covers the empty table, bad and overlapping windows, the table extremes and
// every request code, then random traffic runs under five repeat periods.
// Every accepted item is run through a local copy of the sorted table, and
// each result item is compared field by field with the oldest expectation.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import twsq_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 66;
    localparam int MAX_GAP      = 6;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 40;

    // Request codes that the block does not define.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    typedef struct {
        t_req_item    rq;
        bit           typed;
        t_result_item want;
    } t_script_row;

    // Ports of the block.
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req_item         i_req;
    logic              o_result_valid;
    t_result_item      o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Local copy of the window table and the repeat period.
    logic [31:0] win_lo [CAPACITY];
    logic [31:0] win_hi [CAPACITY];
    logic        win_rec [CAPACITY];
    int          held_windows;
    logic [31:0] period_cfg;

    // Results expected from the block, oldest first.
    t_result_item expected_reports [$];
    t_result_item fresh_reports [$];
    t_result_item head_report;

    t_script_row script [$];
    logic [31:0] period_plan [PHASES];
    logic [31:0] base_plan [PHASES];
    logic [31:0] window_base;
    bit          burst_mode;
    int          mismatch_count;
    int          reports_checked;
    int          requests_taken;
    int          op_tally [8];
    int          stall_ticks;

    time_window_schedule_queue #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_result_valid(o_result_valid),
        .o_result(o_result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_req_item compose_request(logic [2:0] op, logic [31:0] s,
                                                  logic [31:0] e, logic r,
                                                  logic [4:0] dc);
        t_req_item rq;
        rq.req_type   = op;
        rq.start_time = s;
        rq.end_time   = e;
        rq.repeating  = r;
        rq.dump_count = dc;
        return rq;
    endfunction

    function automatic t_result_item compose_report(logic [2:0] st, logic [31:0] s,
                                                    logic [31:0] e, logic r,
                                                    int cnt, logic lst);
        t_result_item rpt;
        rpt.status      = st;
        rpt.start_out   = s;
        rpt.end_out     = e;
        rpt.repeat_out  = r;
        rpt.entry_count = COUNT_OUT_W'(cnt);
        rpt.last        = lst;
        return rpt;
    endfunction

    // Insert a window in start order; the checks run bad, full, then overlap.
    function automatic logic [2:0] table_insert(logic [31:0] s, logic [31:0] e, logic r);
        int pos;
        int i;
        pos = 0;
        if (e <= s) return ST_BAD;
        if (held_windows >= CAPACITY) return ST_FULL;
        while (pos < held_windows && win_lo[pos] < s) pos++;
        if (pos > 0 && s < win_hi[pos-1]) return ST_OVERLAP;
        if (pos < held_windows && e > win_lo[pos]) return ST_OVERLAP;
        for (i = held_windows; i > pos; i--) begin
            win_lo[i]  = win_lo[i-1];
            win_hi[i]  = win_hi[i-1];
            win_rec[i] = win_rec[i-1];
        end
        win_lo[pos]  = s;
        win_hi[pos]  = e;
        win_rec[pos] = r;
        held_windows++;
        return ST_OK;
    endfunction

    function automatic void table_remove(int pos);
        int i;
        for (i = pos; i + 1 < held_windows; i++) begin
            win_lo[i]  = win_lo[i+1];
            win_hi[i]  = win_hi[i+1];
            win_rec[i] = win_rec[i+1];
        end
        held_windows--;
    endfunction

    // Works out the result items of one request and updates the local table.
    function automatic void schedule_forecast(t_req_item rq);
        logic [31:0] hs;
        logic [31:0] he;
        logic        hr;
        logic [2:0]  st;
        int          n;
        int          i;
        int          found;
        fresh_reports.delete();
        case (rq.req_type)
            REQ_PUSH: begin
                st = table_insert(rq.start_time, rq.end_time, rq.repeating);
                fresh_reports.push_back(compose_report(st, '0, '0, 1'b0, held_windows, 1'b1));
            end
            REQ_POP: begin
                if (held_windows == 0) begin
                    fresh_reports.push_back(compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1));
                end else begin
                    hs = win_lo[0];
                    he = win_hi[0];
                    hr = win_rec[0];
                    table_remove(0);
                    // The put-back is dropped when either time would pass 2^32-1.
                    if (hr && ({1'b0, hs} + {1'b0, period_cfg} <= 33'h0_FFFF_FFFF) &&
                        ({1'b0, he} + {1'b0, period_cfg} <= 33'h0_FFFF_FFFF)) begin
                        void'(table_insert(hs + period_cfg, he + period_cfg, 1'b1));
                    end
                    fresh_reports.push_back(compose_report(ST_OK, hs, he, hr,
                                                           held_windows, 1'b1));
                end
            end
            REQ_PEEK: begin
                if (held_windows == 0) begin
                    fresh_reports.push_back(compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1));
                end else begin
                    fresh_reports.push_back(compose_report(ST_OK, win_lo[0], win_hi[0],
                                                           win_rec[0], held_windows, 1'b1));
                end
            end
            REQ_DELETE: begin
                if (held_windows == 0) begin
                    fresh_reports.push_back(compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1));
                end else begin
                    found = -1;
                    for (i = 0; i < held_windows; i++) begin
                        if (found < 0 && win_lo[i] == rq.start_time) found = i;
                    end
                    if (found >= 0) begin
                        table_remove(found);
                        st = ST_OK;
                    end else begin
                        st = ST_NOTFOUND;
                    end
                    fresh_reports.push_back(compose_report(st, '0, '0, 1'b0,
                                                           held_windows, 1'b1));
                end
            end
            REQ_DUMP: begin
                n = rq.dump_count;
                if (n > held_windows) n = held_windows;
                if (n > MAX_DUMP) n = MAX_DUMP;
                if (n == 0) begin
                    st = (held_windows == 0) ? ST_EMPTY : ST_OK;
                    fresh_reports.push_back(compose_report(st, '0, '0, 1'b0,
                                                           held_windows, 1'b1));
                end
                for (i = 0; i < n; i++) begin
                    fresh_reports.push_back(compose_report(ST_OK, win_lo[i], win_hi[i],
                                                           win_rec[i], held_windows,
                                                           i + 1 == n));
                end
            end
            default: begin
                fresh_reports.push_back(compose_report(ST_BAD, '0, '0, 1'b0,
                                                       held_windows, 1'b1));
            end
        endcase
    endfunction

    // Random request: mostly plausible windows near the phase base, plus noise.
    function automatic t_req_item draw_request();
        t_req_item   rq;
        int unsigned pick;
        int unsigned style;
        rq.req_type   = REQ_PEEK;
        rq.start_time = $urandom();
        rq.end_time   = $urandom();
        rq.repeating  = 1'($urandom_range(0, 1));
        rq.dump_count = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            rq.req_type = REQ_PUSH;
            style = $urandom_range(0, 9);
            if (style < 7) begin
                rq.start_time = window_base + $urandom_range(0, 4000);
                rq.end_time   = rq.start_time + $urandom_range(1, 300);
            end else if (style == 7) begin
                rq.end_time = rq.start_time - $urandom_range(0, 3);
            end else if (style == 8) begin
                rq.start_time = 32'hFFFF_FFFF - $urandom_range(0, 600);
                rq.end_time   = $urandom_range(rq.start_time, 32'hFFFF_FFFF);
            end
        end else if (pick < 58) begin
            rq.req_type = REQ_POP;
        end else if (pick < 68) begin
            rq.req_type = REQ_PEEK;
        end else if (pick < 82) begin
            rq.req_type = REQ_DELETE;
            if (held_windows > 0 && $urandom_range(0, 3) != 0) begin
                rq.start_time = win_lo[$urandom_range(0, held_windows - 1)];
            end
        end else if (pick < 97) begin
            rq.req_type = REQ_DUMP;
        end else begin
            rq.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        end
        return rq;
    endfunction

    // Offer one item, wait for it to be taken, then queue its expected results.
    task automatic send_request(input t_req_item rq, input bit typed,
                                input t_result_item want);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req = rq;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        schedule_forecast(rq);
        if (typed) begin
            expected_reports.push_back(want);
        end else begin
            foreach (fresh_reports[k]) expected_reports.push_back(fresh_reports[k]);
        end
        requests_taken++;
        op_tally[rq.req_type]++;
    endtask

    // Drop start and wait until the block has nothing left to report.
    task automatic drain_block();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_reports.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of the repeat period, then a read back of the same register.
    task automatic write_period(input logic [31:0] value);
        logic [31:0] seen;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_PERIOD_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        seen = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        period_cfg = value;
        if (seen !== value) begin
            $display("%0t: repeat period read back mismatch, expected %0h, got %0h",
                     $time, value, seen);
            mismatch_count++;
        end
    endtask

    // Packed windows back to back until the table is full, then two more.
    task automatic fill_table();
        logic [31:0] cursor;
        logic [31:0] len;
        int          tries;
        int          extra;
        bit          was_full;
        cursor = window_base + 4400 + $urandom_range(0, 100);
        tries  = 0;
        extra  = 0;
        while (extra < 2 && tries < CAPACITY + 6) begin
            was_full = (held_windows >= CAPACITY);
            len = $urandom_range(1, 50);
            send_request(compose_request(REQ_PUSH, cursor, cursor + len,
                                         $urandom_range(0, 3) != 0, 5'($urandom())),
                         1'b0, '0);
            cursor = cursor + len + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20));
            if (was_full) extra++;
            tries++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %p", $time, o_result);
                mismatch_count++;
            end else begin
                head_report = expected_reports.pop_front();
                check_field("status", 32'(head_report.status), 32'(o_result.status));
                check_field("start_out", head_report.start_out, o_result.start_out);
                check_field("end_out", head_report.end_out, o_result.end_out);
                check_field("repeat_out", 32'(head_report.repeat_out),
                            32'(o_result.repeat_out));
                check_field("entry_count", 32'(head_report.entry_count),
                            32'(o_result.entry_count));
                check_field("last", 32'(head_report.last), 32'(o_result.last));
            end
            reports_checked++;
        end
    end

    // Watchdog on cycles in which neither an item nor a result is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_ticks <= 0;
        end else begin
            stall_ticks <= stall_ticks + 1;
            if (stall_ticks >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        int k;
        int p;
        int phase_first;
        bit filled;
        start        = 1'b0;
        i_req        = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        held_windows = 0;
        period_cfg   = PERIOD_RESET;
        burst_mode   = 1'b0;
        window_base  = '0;
        stall_ticks  = 0;
        mismatch_count  = 0;
        reports_checked = 0;
        requests_taken  = 0;
        foreach (op_tally[j]) op_tally[j] = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed script, starting from the empty table and the reset period.
        script.push_back(t_script_row'{compose_request(REQ_PEEK, '0, '0, 1'b0, 5'd0), 1'b1,
                         compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_POP, '1, '1, 1'b1, 5'd31), 1'b1,
                         compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_DELETE, '0, '0, 1'b0, 5'd0), 1'b1,
                         compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_DUMP, '0, '0, 1'b0, 5'd5), 1'b1,
                         compose_report(ST_EMPTY, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'd100, 32'd100, 1'b0, 5'd0),
                         1'b1, compose_report(ST_BAD, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_PUSH, '1, '0, 1'b1, 5'd0), 1'b1,
                         compose_report(ST_BAD, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_UNUSED_LO, '0, '0, 1'b0, 5'd0), 1'b1,
                         compose_report(ST_BAD, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_UNUSED_HI, '1, '1, 1'b1, 5'd31),
                         1'b1, compose_report(ST_BAD, '0, '0, 1'b0, 0, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'd0, 32'd10, 1'b1, 5'd0),
                         1'b1, compose_report(ST_OK, '0, '0, 1'b0, 1, 1'b1)});
        // Equal starts always overlap.
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'd0, 32'd5, 1'b0, 5'd0),
                         1'b1, compose_report(ST_OVERLAP, '0, '0, 1'b0, 1, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'd5, 32'd20, 1'b0, 5'd0),
                         1'b1, compose_report(ST_OVERLAP, '0, '0, 1'b0, 1, 1'b1)});
        // Touching the previous window is allowed.
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'd10, 32'd20, 1'b0, 5'd0),
                         1'b1, compose_report(ST_OK, '0, '0, 1'b0, 2, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'hFFFF_FFF0, '1, 1'b1,
                         5'd0), 1'b1, compose_report(ST_OK, '0, '0, 1'b0, 3, 1'b1)});
        // Overlaps the next window only.
        script.push_back(t_script_row'{compose_request(REQ_PUSH, 32'd25, 32'hFFFF_FFF1, 1'b0,
                         5'd0), 1'b1, compose_report(ST_OVERLAP, '0, '0, 1'b0, 3, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_PEEK, '0, '0, 1'b0, 5'd0), 1'b1,
                         compose_report(ST_OK, 32'd0, 32'd10, 1'b1, 3, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_DUMP, '0, '0, 1'b0, 5'd0), 1'b1,
                         compose_report(ST_OK, '0, '0, 1'b0, 3, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_DUMP, '0, '0, 1'b0, 5'd31), 1'b0,
                         '0});
        script.push_back(t_script_row'{compose_request(REQ_DUMP, '0, '0, 1'b0, 5'd2), 1'b0,
                         '0});
        script.push_back(t_script_row'{compose_request(REQ_DELETE, 32'd12345, '0, 1'b0, 5'd0),
                         1'b1, compose_report(ST_NOTFOUND, '0, '0, 1'b0, 3, 1'b1)});
        script.push_back(t_script_row'{compose_request(REQ_DELETE, 32'd10, '0, 1'b0, 5'd0),
                         1'b1, compose_report(ST_OK, '0, '0, 1'b0, 2, 1'b1)});
        // Two pops that put the repeating window back one period later.
        script.push_back(t_script_row'{compose_request(REQ_POP, '0, '0, 1'b0, 5'd0), 1'b0,
                         '0});
        script.push_back(t_script_row'{compose_request(REQ_POP, '0, '0, 1'b0, 5'd0), 1'b0,
                         '0});
        script.push_back(t_script_row'{compose_request(REQ_DELETE, 32'd172800, '0, 1'b0, 5'd0),
                         1'b1, compose_report(ST_OK, '0, '0, 1'b0, 1, 1'b1)});
        // The put-back of a window at the top of the range would wrap.
        script.push_back(t_script_row'{compose_request(REQ_POP, '0, '0, 1'b0, 5'd0), 1'b1,
                         compose_report(ST_OK, 32'hFFFF_FFF0, '1, 1'b1, 0, 1'b1)});
        for (k = 0; k < script.size(); k++) begin
            send_request(script[k].rq, script[k].typed, script[k].want);
        end

        // Random phases, one repeat period each, extremes included.
        period_plan[0] = 32'd1;
        period_plan[1] = 32'hFFFF_FFFF;
        period_plan[2] = $urandom_range(2, 5000);
        period_plan[3] = PERIOD_RESET;
        period_plan[4] = $urandom();
        base_plan[0]   = '0;
        base_plan[1]   = $urandom_range(0, 32'h7FFF_FFFF);
        base_plan[2]   = $urandom_range(0, 32'h7FFF_FFFF);
        base_plan[3]   = 32'hFFFF_E000;
        base_plan[4]   = $urandom_range(0, 32'h7FFF_FFFF);
        for (p = 0; p < PHASES; p++) begin
            drain_block();
            write_period(period_plan[p]);
            window_base = base_plan[p];
            phase_first = requests_taken;
            filled      = 1'b0;
            while (requests_taken - phase_first < PHASE_ITEMS) begin
                if ((requests_taken % 16) == 0) burst_mode = ($urandom_range(0, 3) == 0);
                if (!filled && requests_taken - phase_first >= 20) begin
                    fill_table();
                    filled = 1'b1;
                end else begin
                    send_request(draw_request(), 1'b0, '0);
                end
            end
        end

        drain_block();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        $display("Checked %0d results from %0d requests: %0d push, %0d pop, %0d peek,",
                 reports_checked, requests_taken, op_tally[REQ_PUSH], op_tally[REQ_POP],
                 op_tally[REQ_PEEK]);
        $display("%0d delete, %0d dump, %0d undefined; %0d repeat periods incl. 1 and max.",
                 op_tally[REQ_DELETE], op_tally[REQ_DUMP],
                 op_tally[5] + op_tally[6] + op_tally[7], PHASES);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
